FILE: rtl/core/dslv_pkg.sv
// Shared types, constants and the note frequency function of the voice core.
// No dependencies; every module of the core but dslv_mul imports this package.
package dslv_pkg;

  // Sequencer steps; at most one shared multiplier launch and one product writeback per step
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LFO_HI,
    ST_LFO_LO,
    ST_LFO_ADD,
    ST_S1_LO,
    ST_S1_ADD,
    ST_U2,
    ST_P1,
    ST_P1_WB,
    ST_P2,
    ST_P2_WB,
    ST_P3,
    ST_P3_WB,
    ST_P4,
    ST_P4_WB,
    ST_PU,
    ST_SINE_WB,
    ST_VIB,
    ST_VIB_WB,
    ST_F2,
    ST_F2_WB,
    ST_S2_HI,
    ST_S2_LO,
    ST_S2_ADD,
    ST_MIX,
    ST_MIX_WB,
    ST_GAIN,
    ST_OUT_WB
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_LFO_HI,
    MUL_LFO_LO,
    MUL_FREQ_HI,
    MUL_FREQ_LO,
    MUL_U_U,
    MUL_ENV_DECAY,
    MUL_C0_U2,
    MUL_POLY_U2,
    MUL_POLY_U,
    MUL_LFO_VIB,
    MUL_FREQ_FACTOR,
    MUL_MIX_ENV,
    MUL_GAIN
  } mul_op_t;

  typedef enum logic [4:0] {
    WB_NONE,
    WB_ACC,
    WB_LFO_PHASE,
    WB_SAW1,
    WB_SAW2,
    WB_U2,
    WB_ENV,
    WB_POLY1,
    WB_POLY2,
    WB_POLY3,
    WB_POLY4,
    WB_SINE,
    WB_FACTOR,
    WB_FREQ2,
    WB_MIX_ENV,
    WB_OUT
  } wb_op_t;

  typedef struct packed {
    mul_op_t mul_op;
    wb_op_t  wb_op;
    logic    load;
    logic    set_u;
  } dslv_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dslv_status_t;

  localparam int STEP_W = 36;
  localparam int FREQ_W = 31;

  localparam logic [STEP_W-1:0] STEP_RESET     = 36'd6382652534;
  localparam logic [29:0]       FREQ_IDLE_Q16  = 30'd28835840;
  localparam logic [29:0]       FREQ_LFO_Q16   = 30'd327680;
  localparam logic [16:0]       ENV_ONE        = 17'd65536;
  localparam logic [16:0]       ENV_ATTACK     = 17'd328;
  localparam logic [19:0]       ENV_DECAY_Q20  = 20'd1047527;
  localparam logic [14:0]       OUT_GAIN_Q16   = 15'd19661;
  localparam logic [12:0]       VIB_DEPTH_Q16  = 13'd6554;
  localparam logic signed [17:0] FACTOR_BASE   = 18'sd65536;
  localparam logic [30:0]       POLY_C0        = 31'd172272;
  localparam logic [30:0]       POLY_C1        = 31'd5026995;
  localparam logic [30:0]       POLY_C2        = 31'd85569306;
  localparam logic [30:0]       POLY_C3        = 31'd693598669;
  localparam logic [30:0]       POLY_C4        = 31'd1686629713;
  localparam logic [30:0]       U_ONE          = 31'd1073741824;
  localparam logic [31:0]       ROUND_Q15      = 32'd16384;
  localparam logic [16:0]       LFO_MAG_MAX    = 17'd32767;

  // Top octave (notes 120..131) in Q16 Hz
  function automatic logic [29:0] top_octave_q16(input logic [3:0] semi);
    logic [29:0] f;
    unique case (semi)
      4'd0:    f = 30'd548668578;
      4'd1:    f = 30'd581294109;
      4'd2:    f = 30'd615859655;
      4'd3:    f = 30'd652480576;
      4'd4:    f = 30'd691279090;
      4'd5:    f = 30'd732384684;
      4'd6:    f = 30'd775934544;
      4'd7:    f = 30'd822074013;
      4'd8:    f = 30'd870957077;
      4'd9:    f = 30'd922746880;
      4'd10:   f = 30'd977616265;
      4'd11:   f = 30'd1035748353;
      default: f = 30'd0;
    endcase
    return f;
  endfunction

  // Equal-temperament note frequency in Q16 Hz, rounded octave shift
  function automatic logic [29:0] note_freq_q16(input logic [6:0] note);
    logic [3:0]  octave;
    logic [6:0]  semi;
    logic [3:0]  shift;
    logic [29:0] base;
    logic [30:0] rounded;
    octave = 4'd0;
    for (int k = 1; k <= 10; k++) begin
      if (note >= 7'(12 * k)) octave = 4'(k);
    end
    semi  = note - (7'(octave) * 7'd12);
    shift = 4'd10 - octave;
    base  = top_octave_q16(semi[3:0]);
    if (shift == 4'd0) begin
      return base;
    end
    rounded = 31'(base) + (31'd1 << (shift - 4'd1));
    return 30'(rounded >> shift);
  endfunction

endpackage

FILE: rtl/core/dslv_mul.sv
// Shared signed 33x33 multiplier with a registered product.
// Depends on nothing; used by the voice datapath.
module dslv_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod
);

  // Hold the product while idle so a stalled writeback still sees it
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

FILE: rtl/core/dslv_ctrl.sv
// Sequencer of the voice core: steps the datapath through one sample.
// Depends on dslv_pkg.
module dslv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dslv_pkg::dslv_status_t status,
  output dslv_pkg::dslv_cmd_t    cmd
);
  import dslv_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '{mul_op: MUL_NONE, wb_op: WB_NONE, load: 1'b0, set_u: 1'b0};
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // Take no beat while reset is held
        in_ready = !rst;
        cmd.load = in_valid && !rst;
        if (in_valid && !rst) state_next = ST_LFO_HI;
      end
      ST_LFO_HI: begin
        cmd.mul_op = MUL_LFO_HI;
        state_next = ST_LFO_LO;
      end
      ST_LFO_LO: begin
        cmd.mul_op = MUL_LFO_LO;
        cmd.wb_op  = WB_ACC;
        state_next = ST_LFO_ADD;
      end
      ST_LFO_ADD: begin
        cmd.mul_op = MUL_FREQ_HI;
        cmd.wb_op  = WB_LFO_PHASE;
        state_next = ST_S1_LO;
      end
      ST_S1_LO: begin
        cmd.mul_op = MUL_FREQ_LO;
        cmd.wb_op  = WB_ACC;
        cmd.set_u  = 1'b1;
        state_next = ST_S1_ADD;
      end
      ST_S1_ADD: begin
        cmd.mul_op = MUL_U_U;
        cmd.wb_op  = WB_SAW1;
        state_next = ST_U2;
      end
      ST_U2: begin
        cmd.mul_op = MUL_ENV_DECAY;
        cmd.wb_op  = WB_U2;
        state_next = ST_P1;
      end
      ST_P1: begin
        cmd.mul_op = MUL_C0_U2;
        cmd.wb_op  = WB_ENV;
        state_next = ST_P1_WB;
      end
      ST_P1_WB: begin
        cmd.wb_op  = WB_POLY1;
        state_next = ST_P2;
      end
      ST_P2: begin
        cmd.mul_op = MUL_POLY_U2;
        state_next = ST_P2_WB;
      end
      ST_P2_WB: begin
        cmd.wb_op  = WB_POLY2;
        state_next = ST_P3;
      end
      ST_P3: begin
        cmd.mul_op = MUL_POLY_U2;
        state_next = ST_P3_WB;
      end
      ST_P3_WB: begin
        cmd.wb_op  = WB_POLY3;
        state_next = ST_P4;
      end
      ST_P4: begin
        cmd.mul_op = MUL_POLY_U2;
        state_next = ST_P4_WB;
      end
      ST_P4_WB: begin
        cmd.wb_op  = WB_POLY4;
        state_next = ST_PU;
      end
      ST_PU: begin
        cmd.mul_op = MUL_POLY_U;
        state_next = ST_SINE_WB;
      end
      ST_SINE_WB: begin
        cmd.wb_op  = WB_SINE;
        state_next = ST_VIB;
      end
      ST_VIB: begin
        cmd.mul_op = MUL_LFO_VIB;
        state_next = ST_VIB_WB;
      end
      ST_VIB_WB: begin
        cmd.wb_op  = WB_FACTOR;
        state_next = ST_F2;
      end
      ST_F2: begin
        cmd.mul_op = MUL_FREQ_FACTOR;
        state_next = ST_F2_WB;
      end
      ST_F2_WB: begin
        cmd.wb_op  = WB_FREQ2;
        state_next = ST_S2_HI;
      end
      ST_S2_HI: begin
        cmd.mul_op = MUL_FREQ_HI;
        state_next = ST_S2_LO;
      end
      ST_S2_LO: begin
        cmd.mul_op = MUL_FREQ_LO;
        cmd.wb_op  = WB_ACC;
        state_next = ST_S2_ADD;
      end
      ST_S2_ADD: begin
        cmd.wb_op  = WB_SAW2;
        state_next = ST_MIX;
      end
      ST_MIX: begin
        cmd.mul_op = MUL_MIX_ENV;
        state_next = ST_MIX_WB;
      end
      ST_MIX_WB: begin
        cmd.wb_op  = WB_MIX_ENV;
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.mul_op = MUL_GAIN;
        state_next = ST_OUT_WB;
      end
      ST_OUT_WB: begin
        // Hold here while the previous sample still sits in the output register
        if (!status.out_busy) begin
          cmd.wb_op  = WB_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/dslv_datapath.sv
// Datapath of the voice core: phases, envelope, LFO polynomial, output register.
// Depends on dslv_pkg and dslv_mul; driven by dslv_ctrl commands.
module dslv_datapath #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dslv_pkg::dslv_cmd_t          cmd,
  output dslv_pkg::dslv_status_t       status,
  input  logic                         note_active,
  input  logic [6:0]                   note_number,
  input  logic                         envelope_restart,
  input  logic                         cfg_we,
  input  logic [dslv_pkg::STEP_W-1:0]  cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [15:0]           sample_out
);
  import dslv_pkg::*;

  localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH);
  localparam int INC_SHIFT = 46 - PHASE_BITS;

  logic [STEP_W-1:0]      step_reg;
  logic [PHASE_BITS-1:0]  lfo_phase;
  logic [PHASE_BITS-1:0]  saw_one_phase;
  logic [PHASE_BITS-1:0]  saw_two_phase;
  logic [16:0]            envelope_level;
  logic                   active;
  logic [FREQ_W-1:0]      freq;
  logic [48:0]            acc;
  logic [1:0]             quad;
  logic [30:0]            u;
  logic [30:0]            u2;
  logic [30:0]            poly;
  logic signed [15:0]     lfo;
  logic [16:0]            factor;
  logic signed [32:0]     mix_env;

  logic signed [32:0]     mul_a;
  logic signed [32:0]     mul_b;
  logic signed [65:0]     prod;
  logic                   mul_en;

  logic [IDX_W-1:0]       lfo_idx;
  logic [29:0]            u_base;
  logic [49:0]            inc_sum;
  logic [49:0]            inc_wide;
  logic [PHASE_BITS-1:0]  phase_inc;
  logic [30:0]            prod_q30;
  logic [31:0]            sine_round;
  logic [16:0]            sine_mag;
  logic [14:0]            lfo_mag;
  logic [17:0]            env_attack;
  logic [17:0]            factor_sum;
  logic [PHASE_BITS:0]    saw_sum;
  logic [15:0]            mix_u;
  logic signed [15:0]     mix;

  assign status.out_busy = out_valid && !out_ready;

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MUL_LFO_HI: begin
        mul_a = 33'(FREQ_LFO_Q16);
        mul_b = 33'(step_reg[STEP_W-1:18]);
      end
      MUL_LFO_LO: begin
        mul_a = 33'(FREQ_LFO_Q16);
        mul_b = 33'(step_reg[17:0]);
      end
      MUL_FREQ_HI: begin
        mul_a = 33'(freq);
        mul_b = 33'(step_reg[STEP_W-1:18]);
      end
      MUL_FREQ_LO: begin
        mul_a = 33'(freq);
        mul_b = 33'(step_reg[17:0]);
      end
      MUL_U_U: begin
        mul_a = 33'(u);
        mul_b = 33'(u);
      end
      MUL_ENV_DECAY: begin
        mul_a = 33'(envelope_level);
        mul_b = 33'(ENV_DECAY_Q20);
      end
      MUL_C0_U2: begin
        mul_a = 33'(POLY_C0);
        mul_b = 33'(u2);
      end
      MUL_POLY_U2: begin
        mul_a = 33'(poly);
        mul_b = 33'(u2);
      end
      MUL_POLY_U: begin
        mul_a = 33'(poly);
        mul_b = 33'(u);
      end
      MUL_LFO_VIB: begin
        mul_a = 33'(lfo);
        mul_b = 33'(VIB_DEPTH_Q16);
      end
      MUL_FREQ_FACTOR: begin
        mul_a = 33'(freq);
        mul_b = 33'(factor);
      end
      MUL_MIX_ENV: begin
        mul_a = 33'(mix);
        mul_b = 33'(envelope_level);
      end
      MUL_GAIN: begin
        mul_a = mix_env;
        mul_b = 33'(OUT_GAIN_Q16);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_en = (cmd.mul_op != MUL_NONE);

  dslv_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Phase increment: high partial plus the low partial scaled down by 2^18
  assign inc_sum   = 50'(acc) + 50'(prod[48:18]);
  assign inc_wide  = inc_sum >> INC_SHIFT;
  assign phase_inc = inc_wide[PHASE_BITS-1:0];

  // Quarter-wave argument from the top bits of the LFO phase
  assign lfo_idx = lfo_phase[PHASE_BITS-1 -: IDX_W];
  assign u_base  = 30'(lfo_idx[IDX_W-3:0]) << (32 - IDX_W);

  assign prod_q30   = prod[60:30];
  assign sine_round = 32'(prod_q30) + ROUND_Q15;
  assign sine_mag   = sine_round[31:15];
  assign lfo_mag    = (sine_mag > LFO_MAG_MAX) ? LFO_MAG_MAX[14:0] : sine_mag[14:0];

  assign env_attack = 18'(envelope_level) + 18'(ENV_ATTACK);
  assign factor_sum = 18'(FACTOR_BASE + $signed(prod[32:15]));

  assign saw_sum = {1'b0, saw_one_phase} + {1'b0, saw_two_phase};
  assign mix_u   = saw_sum[PHASE_BITS -: 16];
  assign mix     = $signed({~mix_u[15], mix_u[14:0]});

  // Architectural state: phases, envelope and the step register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg       <= STEP_RESET;
      lfo_phase      <= '0;
      saw_one_phase  <= '0;
      saw_two_phase  <= '0;
      envelope_level <= '0;
    end else begin
      if (cfg_we) begin
        step_reg <= cfg_data;
      end
      if (cmd.load && envelope_restart) begin
        envelope_level <= '0;
      end
      unique case (cmd.wb_op)
        WB_LFO_PHASE: lfo_phase     <= lfo_phase + phase_inc;
        WB_SAW1:      saw_one_phase <= saw_one_phase + phase_inc;
        WB_SAW2:      saw_two_phase <= saw_two_phase + phase_inc;
        WB_ENV: begin
          if (active) begin
            envelope_level <= (env_attack > 18'(ENV_ONE)) ? ENV_ONE : env_attack[16:0];
          end else begin
            envelope_level <= prod[36:20];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of one sample
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      active <= note_active;
      freq   <= note_active ? 31'(note_freq_q16(note_number)) : 31'(FREQ_IDLE_Q16);
    end
    if (cmd.set_u) begin
      quad <= lfo_idx[IDX_W-1 -: 2];
      // Mirror the falling quarters
      if (lfo_idx[IDX_W-2]) begin
        u <= U_ONE - 31'(u_base);
      end else begin
        u <= 31'(u_base);
      end
    end
    unique case (cmd.wb_op)
      WB_ACC:     acc     <= prod[48:0];
      WB_U2:      u2      <= prod_q30;
      WB_POLY1:   poly    <= POLY_C1 - prod_q30;
      WB_POLY2:   poly    <= POLY_C2 - prod_q30;
      WB_POLY3:   poly    <= POLY_C3 - prod_q30;
      WB_POLY4:   poly    <= POLY_C4 - prod_q30;
      WB_SINE:    lfo     <= quad[1] ? -$signed({1'b0, lfo_mag}) : $signed({1'b0, lfo_mag});
      WB_FACTOR:  factor  <= factor_sum[16:0];
      WB_FREQ2:   freq    <= prod[46:16];
      WB_MIX_ENV: mix_env <= prod[32:0];
      default: begin
      end
    endcase
  end

  // Output register: fill on writeback, drain on handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.wb_op == WB_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb_op == WB_OUT) begin
      sample_out <= $signed(prod[47:32]);
    end
  end

endmodule

FILE: rtl/core/dual_saw_lfo_synth_voice_core.sv
// Top level of the dual sawtooth synth voice with sine LFO vibrato.
// Depends on dslv_pkg, dslv_ctrl, dslv_datapath (which holds dslv_mul).
//
//  Channel   Handshake                 Payload (lowest bit first)
//  -------   ------------------------  -------------------------------------------
//  s_axis    s_axis_tvalid/tready      tdata: note_number[6:0], zero pad [7]
//                                      tuser: note_active [0], envelope_restart [1]
//  m_axis    m_axis_tvalid/tready      tdata: sample_out[15:0] (Q15, signed)
//  cfg       cfg_valid/cfg_ready       cfg_data: phase_step_per_hz[35:0]
//
// A new beat is taken only after the previous sample has reached the output
// register: every multiply of the sample (phase increments, LFO sine polynomial,
// vibrato, envelope decay, envelope scaling, output gain) goes through one
// shared registered 33x33 multiplier, at most one launch per cycle, so that
// unit sets the pace.
// rst is synchronous: it restores the 44.1 kHz step and clears phases and envelope.
// A new beat is taken only in the idle step; the finished sample waits in the
// output register, and the core stalls before its last writeback only while
// that register is still full and not drained.
// cfg_ready is always high; write configuration only while the core is idle.
module dual_saw_lfo_synth_voice_core #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  // input sample ticks
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [6:0] note_number, [7] zero
  input  logic [1:0]                  s_axis_tuser,   // [0] note_active, [1] envelope_restart
  // output samples
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,   // [15:0] sample_out
  // phase step register
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dslv_pkg::STEP_W-1:0] cfg_data        // [35:0] phase_step_per_hz
);
  import dslv_pkg::*;

  dslv_cmd_t          cmd;
  dslv_status_t       status;
  logic signed [15:0] sample_out;

  // Always take configuration beats
  assign cfg_ready = 1'b1;

  dslv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dslv_datapath #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .note_active      (s_axis_tuser[0]),
    .note_number      (s_axis_tdata[6:0]),
    .envelope_restart (s_axis_tuser[1]),
    .cfg_we           (cfg_valid),
    .cfg_data         (cfg_data),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .sample_out       (sample_out)
  );

  assign m_axis_tdata = sample_out;

endmodule
